/* rtl/core/ttq_pkg.sv */
// Shared types and constants for the timed task queue.
`timescale 1ns / 1ps

package ttq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned WAIT_W    = 32;
  localparam int unsigned IDLE_W    = 16;

  localparam logic [IDLE_W-1:0] IDLE_WAIT_RST = 16'd120;

  typedef enum logic [1:0] {
    FUNC_SCHEDULE = 2'd0,
    FUNC_CHECK    = 2'd1,
    FUNC_REMOVE   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_NOT_DUE   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_INS,
    S_PUT,
    S_DEL,
    S_DONE
  } fsm_e;

  typedef struct packed {
    func_e              func;
    logic [TIME_W-1:0]  now_secs;
    logic [TAG_W-1:0]   task_tag;
    logic [TIME_W-1:0]  delay_secs;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [TAG_W-1:0]   out_tag;
    logic [WAIT_W-1:0]  wait_secs;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  due;
  } entry_t;

endpackage

/* rtl/core/ttq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ttq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/timed_task_queue.sv */
// Top level of the timed task queue: sequencer, shared compare unit and entry RAM.
`timescale 1ns / 1ps

// The queue keeps up to DEPTH tasks (tag, due second) in ascending order of
// due time in one RAM. An item arrives on in_valid_i/in_stall_o with a func
// code: schedule inserts a task at now + delay, check pops the head when it
// is due or reports the wait, remove deletes the first entry with a tag.
// Every item gives exactly one result on out_valid_o/out_stall_i.
// The idle wait register is written through cfg_we_i/cfg_data_i; the user
// must write it only while the queue is idle, which the block itself does not enforce; it resets to 120.
// One item is in work at a time and in_stall_o is high until its result
// is placed in the output register. Schedule, a check that pops and remove
// walk the RAM one entry per cycle, shifting entries up or down through its
// single write port. The longest item is a schedule in front of 15 entries.
// A result held by a stalled receiver does not block the next item from
// being accepted; only the following result waits for the output register.
// Reset empties the queue at once; the RAM contents need no clearing.
module timed_task_queue #(
  parameter int unsigned DEPTH = ttq_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ttq_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ttq_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [ttq_pkg::IDLE_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ttq_pkg::fsm_e              st_q, st_d;
  ttq_pkg::func_e             op_q, op_d;
  logic [ttq_pkg::TIME_W-1:0] now_q, now_d;
  logic [ttq_pkg::TAG_W-1:0]  tag_q, tag_d;
  logic [ttq_pkg::TIME_W-1:0] due_q, due_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [ttq_pkg::IDLE_W-1:0] idle_q;
  logic [AW-1:0]              idx_q, idx_d;
  logic                       front_q, front_d;
  logic                       found_q, found_d;
  ttq_pkg::out_item_t         res_q, res_d;
  ttq_pkg::out_item_t         out_q, out_d;
  logic                       out_vld_q, out_vld_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  ttq_pkg::entry_t            ram_wdata;
  logic [AW-1:0]              ram_raddr;
  ttq_pkg::entry_t            ram_rdata;

  logic                       accept;
  logic                       slot_free;
  logic [ttq_pkg::TIME_W:0]   due_sum;
  logic [ttq_pkg::TIME_W-1:0] due_sat;
  logic [ttq_pkg::TIME_W-1:0] cmp_a, cmp_b;
  logic                       cmp_le;
  logic                       move;
  logic                       last;
  logic                       match;
  logic [CW-1:0]              cnt_m1;
  logic [ttq_pkg::TIME_W-1:0] diff;

  ttq_ram #(
    .WIDTH ($bits(ttq_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ttq_pkg::S_IDLE);
  assign slot_free = !out_vld_q || !out_stall_i;

  // Due time of a new task, saturated at the largest time value.
  assign due_sum = {1'b0, in_item_i.now_secs} + {1'b0, in_item_i.delay_secs};
  assign due_sat = due_sum[ttq_pkg::TIME_W] ? '1 : due_sum[ttq_pkg::TIME_W-1:0];

  // The one shared comparator: head against the new due time or against now
  // in the head state, a scanned entry against the new due time otherwise.
  always_comb begin
    cmp_a = ram_rdata.due;
    cmp_b = due_q;
    if (st_q == ttq_pkg::S_HEAD) begin
      if (op_q == ttq_pkg::FUNC_SCHEDULE) begin
        cmp_a = due_q;
        cmp_b = ram_rdata.due;
      end else begin
        cmp_a = ram_rdata.due;
        cmp_b = now_q;
      end
    end
  end

  assign cmp_le = (cmp_a <= cmp_b);
  assign move   = front_q || !cmp_le;
  assign cnt_m1 = cnt_q - CW'(1);
  assign last   = (CW'(idx_q) == cnt_m1);
  assign match  = !found_q && (ram_rdata.tag == tag_q);
  assign diff   = ram_rdata.due - now_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ttq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_item_i.func)
            ttq_pkg::FUNC_SCHEDULE: begin
              st_d = (cnt_q == CW'(DEPTH)) ? ttq_pkg::S_DONE : ttq_pkg::S_HEAD;
            end
            ttq_pkg::FUNC_CHECK: st_d = ttq_pkg::S_HEAD;
            ttq_pkg::FUNC_REMOVE: begin
              st_d = (cnt_q == '0) ? ttq_pkg::S_DONE : ttq_pkg::S_DEL;
            end
            default: st_d = ttq_pkg::S_DONE;
          endcase
        end
      end
      ttq_pkg::S_HEAD: begin
        st_d = ttq_pkg::S_DONE;
        if (op_q == ttq_pkg::FUNC_SCHEDULE) begin
          if (cnt_q != '0) begin
            st_d = ttq_pkg::S_INS;
          end
        end else if (op_q == ttq_pkg::FUNC_CHECK) begin
          if (cnt_q > CW'(1) && cmp_le) begin
            st_d = ttq_pkg::S_DEL;
          end
        end
      end
      ttq_pkg::S_INS: begin
        if (!move) begin
          st_d = ttq_pkg::S_DONE;
        end else if (idx_q == '0) begin
          st_d = ttq_pkg::S_PUT;
        end
      end
      ttq_pkg::S_PUT: st_d = ttq_pkg::S_DONE;
      ttq_pkg::S_DEL: begin
        if (last) begin
          st_d = ttq_pkg::S_DONE;
        end
      end
      ttq_pkg::S_DONE: begin
        if (slot_free) begin
          st_d = ttq_pkg::S_IDLE;
        end
      end
      default: st_d = ttq_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM port and result register.
  always_comb begin
    op_d      = op_q;
    now_d     = now_q;
    tag_d     = tag_q;
    due_d     = due_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    front_d   = front_q;
    found_d   = found_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = '0;

    unique case (st_q)
      ttq_pkg::S_IDLE: begin
        if (accept) begin
          op_d    = in_item_i.func;
          now_d   = in_item_i.now_secs;
          tag_d   = in_item_i.task_tag;
          due_d   = due_sat;
          idx_d   = '0;
          found_d = 1'b0;
          res_d   = '{status: ttq_pkg::ST_DONE, out_tag: '0, wait_secs: '0};
          if (in_item_i.func == ttq_pkg::FUNC_SCHEDULE && cnt_q == CW'(DEPTH)) begin
            res_d.status = ttq_pkg::ST_FULL;
          end
          if (in_item_i.func == ttq_pkg::FUNC_REMOVE && cnt_q == '0) begin
            res_d.status = ttq_pkg::ST_NOT_FOUND;
          end
        end
      end
      ttq_pkg::S_HEAD: begin
        if (op_q == ttq_pkg::FUNC_SCHEDULE) begin
          // A task due at or before the head goes in front of it.
          front_d = (cnt_q == '0) || cmp_le;
          if (cnt_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{tag: tag_q, due: due_q};
            cnt_d     = cnt_q + CW'(1);
          end else begin
            ram_raddr = cnt_m1[AW-1:0];
            idx_d     = cnt_m1[AW-1:0];
          end
        end else if (op_q == ttq_pkg::FUNC_CHECK) begin
          if (cnt_q == '0) begin
            res_d.status    = ttq_pkg::ST_EMPTY;
            res_d.wait_secs = ttq_pkg::WAIT_W'(idle_q);
          end else if (cmp_le) begin
            res_d.out_tag = ram_rdata.tag;
            if (cnt_q == CW'(1)) begin
              cnt_d = '0;
            end else begin
              found_d   = 1'b1;
              idx_d     = AW'(1);
              ram_raddr = AW'(1);
            end
          end else begin
            res_d.status    = ttq_pkg::ST_NOT_DUE;
            res_d.wait_secs = diff;
          end
        end
      end
      ttq_pkg::S_INS: begin
        // Walk down from the tail, moving later entries up by one.
        ram_we    = 1'b1;
        ram_waddr = idx_q + AW'(1);
        if (move) begin
          ram_wdata = ram_rdata;
          if (idx_q != '0) begin
            idx_d     = idx_q - AW'(1);
            ram_raddr = idx_q - AW'(1);
          end
        end else begin
          ram_wdata = '{tag: tag_q, due: due_q};
          cnt_d     = cnt_q + CW'(1);
        end
      end
      ttq_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{tag: tag_q, due: due_q};
        cnt_d     = cnt_q + CW'(1);
      end
      ttq_pkg::S_DEL: begin
        // Once the entry to drop is found, every later entry moves down one.
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end else if (match) begin
          found_d       = 1'b1;
          res_d.out_tag = ram_rdata.tag;
        end
        if (last) begin
          if (found_q || match) begin
            cnt_d = cnt_m1;
          end else begin
            res_d.status = ttq_pkg::ST_NOT_FOUND;
          end
        end else begin
          idx_d     = idx_q + AW'(1);
          ram_raddr = idx_q + AW'(1);
        end
      end
      ttq_pkg::S_DONE: begin
        if (slot_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ttq_pkg::S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      idle_q    <= ttq_pkg::IDLE_WAIT_RST;
      front_q   <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      front_q   <= front_d;
      found_q   <= found_d;
      if (cfg_we_i) begin
        idle_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    now_q <= now_d;
    tag_q <= tag_d;
    due_q <= due_d;
    idx_q <= idx_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/core/ttq_checker.sv */
// Port-level checks for the timed task queue, bound to the top level.
`timescale 1ns / 1ps

module ttq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input ttq_pkg::in_item_t          in_item_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input ttq_pkg::out_item_t         out_item_o,
  input logic                       cfg_we_i,
  input logic [ttq_pkg::IDLE_W-1:0] cfg_data_i
);

  // A held result stays offered until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  // The queue works on one item at a time, so it is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in work");

  // A full or not-found result carries no tag and no wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ttq_pkg::ST_FULL ||
                    out_item_o.status == ttq_pkg::ST_NOT_FOUND)
    |-> out_item_o.out_tag == '0 && out_item_o.wait_secs == '0)
    else $error("failed operation returned a tag or wait");

endmodule

bind timed_task_queue ttq_checker u_ttq_checker (.*);
